// ----- rtl/core/ppc_pkg.sv -----
`timescale 1ns / 1ps

package ppc_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_VERTICES_DEF = 1024;
    localparam int COORD_BITS_DEF   = 32;

    // Coordinate ports are always this wide; COORD_BITS low bits are used
    localparam int COORD_PORT_W = 32;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Command codes
    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_CLEAR = 2'd0;
    localparam t_cmd CMD_LOAD  = 2'd1;
    localparam t_cmd CMD_QUERY = 2'd2;

    // Control part of one queued word
    typedef struct packed {
        t_cmd cmd;
        logic hole;
        logic ends;
    } t_item_ctl;

    // Tag that travels with one edge test
    typedef struct packed {
        logic valid;
        logic last;
        logic hole;
    } t_edge_tag;

    // Edge tester result and pipeline status
    typedef struct packed {
        logic busy;
        logic valid;
        logic last;
        logic hole;
        logic toggle;
    } t_edge_res;

endpackage

// ----- rtl/core/polygon_point_containment.sv -----
`timescale 1ns / 1ps

// Channel | Handshake                   | Words
// --------+-----------------------------+------------------------------------------------
// input   | i_in_valid / o_in_ready     | i_command, i_coord_x, i_coord_y,
//         |                             | i_ring_is_hole, i_ring_ends
// output  | o_out_valid / i_out_ready   | o_inside_res, o_store_overflowed
//
// Clear and load words are handled one at a time in the back end; unused commands are
// dropped at the front. A query walks the N stored vertices of its R closed rings:
// one store read per vertex, one extra step per ring for its wrap edge, then the
// registered store read and the four-stage edge tester.
// Reset is synchronous, active low, and empties the store and the queue.
// The front keeps taking words into its queue while a query runs or a result waits, until the queue is full.

module polygon_point_containment #(
    parameter int MAX_VERTICES = ppc_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = ppc_pkg::COORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_command,
    input  logic signed [ppc_pkg::COORD_PORT_W-1:0] i_coord_x,
    input  logic signed [ppc_pkg::COORD_PORT_W-1:0] i_coord_y,
    input  logic                             i_ring_is_hole,
    input  logic                             i_ring_ends,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_inside_res,
    output logic                             o_store_overflowed
);

    logic                         q_valid;
    logic                         q_ready;
    ppc_pkg::t_item_ctl           q_ctl;
    logic signed [COORD_BITS-1:0] q_x, q_y;

    // Front: accept, classify, queue
    ppc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_ring_is_hole (i_ring_is_hole),
        .i_ring_ends    (i_ring_ends),
        .o_q_valid      (q_valid),
        .i_q_ready      (q_ready),
        .o_q_ctl        (q_ctl),
        .o_q_x          (q_x),
        .o_q_y          (q_y)
    );

    // Back: vertex store, ring walk, result register
    ppc_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .o_q_ready          (q_ready),
        .i_q_ctl            (q_ctl),
        .i_q_x              (q_x),
        .i_q_y              (q_y),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_inside_res       (o_inside_res),
        .o_store_overflowed (o_store_overflowed)
    );

endmodule

// ----- rtl/core/ppc_ram.sv -----
`timescale 1ns / 1ps

module ppc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/ppc_edge.sv -----
`timescale 1ns / 1ps

module ppc_edge #(
    parameter int COORD_BITS = ppc_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ppc_pkg::t_edge_tag           i_tag,
    input  logic signed [COORD_BITS-1:0] i_xi,
    input  logic signed [COORD_BITS-1:0] i_yi,
    input  logic signed [COORD_BITS-1:0] i_xj,
    input  logic signed [COORD_BITS-1:0] i_yj,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    output ppc_pkg::t_edge_res           o_res
);

    // Differences are one bit wider than coordinates; products split in two halves
    localparam int W1   = COORD_BITS + 1;
    localparam int LO_W = W1 / 2;
    localparam int HI_W = W1 - LO_W;
    localparam int PW   = 2 * W1;
    localparam int PH_W = HI_W + W1;
    localparam int PL_W = LO_W + 1 + W1;

    // Stage 1: differences, sign correction, crossing test
    logic signed [W1-1:0] xi_e, yi_e, xj_e, yj_e, px_e, py_e;
    logic signed [W1-1:0] dy, dx;
    logic signed [W1-1:0] n1_a, n1_b, n1_dx, n1_ady;
    logic                 n1_cross;

    assign xi_e = {i_xi[COORD_BITS-1], i_xi};
    assign yi_e = {i_yi[COORD_BITS-1], i_yi};
    assign xj_e = {i_xj[COORD_BITS-1], i_xj};
    assign yj_e = {i_yj[COORD_BITS-1], i_yj};
    assign px_e = {i_px[COORD_BITS-1], i_px};
    assign py_e = {i_py[COORD_BITS-1], i_py};

    always_comb begin
        dy       = yj_e - yi_e;
        dx       = xj_e - xi_e;
        n1_a     = px_e - xi_e;
        n1_b     = py_e - yi_e;
        n1_ady   = dy;
        n1_dx    = dx;
        if (dy[W1-1]) begin
            n1_ady = -dy;
            n1_dx  = -dx;
        end
        n1_cross = (i_yi > i_py) != (i_yj > i_py);
    end

    ppc_pkg::t_edge_tag   r1_tag;
    logic                 r1_cross;
    logic signed [W1-1:0] r1_a, r1_b, r1_dx, r1_ady;

    // Stage 2: partial products, high and low halves of the left factors
    logic signed [HI_W-1:0] a_hi, dx_hi;
    logic signed [LO_W:0]   a_lo, dx_lo;
    logic signed [PH_W-1:0] n2_lh, n2_rh;
    logic signed [PL_W-1:0] n2_ll, n2_rl;

    assign a_hi  = r1_a[W1-1:LO_W];
    assign a_lo  = {1'b0, r1_a[LO_W-1:0]};
    assign dx_hi = r1_dx[W1-1:LO_W];
    assign dx_lo = {1'b0, r1_dx[LO_W-1:0]};
    assign n2_lh = a_hi * r1_ady;
    assign n2_ll = a_lo * r1_ady;
    assign n2_rh = dx_hi * r1_b;
    assign n2_rl = dx_lo * r1_b;

    ppc_pkg::t_edge_tag     r2_tag;
    logic                   r2_cross;
    logic signed [PH_W-1:0] r2_lh, r2_rh;
    logic signed [PL_W-1:0] r2_ll, r2_rl;

    // Stage 3: recombine both full products
    logic signed [PW-1:0] n3_lhs, n3_rhs;

    assign n3_lhs = {r2_lh, {LO_W{1'b0}}} + {{(PW-PL_W){r2_ll[PL_W-1]}}, r2_ll};
    assign n3_rhs = {r2_rh, {LO_W{1'b0}}} + {{(PW-PL_W){r2_rl[PL_W-1]}}, r2_rl};

    ppc_pkg::t_edge_tag   r3_tag;
    logic                 r3_cross;
    logic signed [PW-1:0] r3_lhs, r3_rhs;

    // Stage 4: exact compare of the crossing abscissa
    logic n4_toggle;

    assign n4_toggle = r3_cross && (r3_lhs < r3_rhs);

    ppc_pkg::t_edge_tag r4_tag;
    logic               r4_toggle;

    // Tags: control, cleared on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag <= '0;
            r2_tag <= '0;
            r3_tag <= '0;
            r4_tag <= '0;
        end else begin
            r1_tag <= i_tag;
            r2_tag <= r1_tag;
            r3_tag <= r2_tag;
            r4_tag <= r3_tag;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r1_cross  <= n1_cross;
        r1_a      <= n1_a;
        r1_b      <= n1_b;
        r1_dx     <= n1_dx;
        r1_ady    <= n1_ady;
        r2_cross  <= r1_cross;
        r2_lh     <= n2_lh;
        r2_ll     <= n2_ll;
        r2_rh     <= n2_rh;
        r2_rl     <= n2_rl;
        r3_cross  <= r2_cross;
        r3_lhs    <= n3_lhs;
        r3_rhs    <= n3_rhs;
        r4_toggle <= n4_toggle;
    end

    assign o_res.busy   = r1_tag.valid || r2_tag.valid || r3_tag.valid || r4_tag.valid;
    assign o_res.valid  = r4_tag.valid;
    assign o_res.last   = r4_tag.last;
    assign o_res.hole   = r4_tag.hole;
    assign o_res.toggle = r4_toggle;

endmodule

// ----- rtl/core/ppc_front.sv -----
`timescale 1ns / 1ps

module ppc_front #(
    parameter int COORD_BITS = ppc_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  ppc_pkg::t_cmd                      i_command,
    input  logic [ppc_pkg::COORD_PORT_W-1:0]   i_coord_x,
    input  logic [ppc_pkg::COORD_PORT_W-1:0]   i_coord_y,
    input  logic                               i_ring_is_hole,
    input  logic                               i_ring_ends,
    output logic                               o_q_valid,
    input  logic                               i_q_ready,
    output ppc_pkg::t_item_ctl                 o_q_ctl,
    output logic signed [COORD_BITS-1:0]       o_q_x,
    output logic signed [COORD_BITS-1:0]       o_q_y
);

    localparam int QAW = $clog2(ppc_pkg::QUEUE_DEPTH);
    localparam int QCW = $clog2(ppc_pkg::QUEUE_DEPTH + 1);

    ppc_pkg::t_item_ctl           r_q_ctl [ppc_pkg::QUEUE_DEPTH];
    logic [COORD_BITS-1:0]        r_q_x   [ppc_pkg::QUEUE_DEPTH];
    logic [COORD_BITS-1:0]        r_q_y   [ppc_pkg::QUEUE_DEPTH];
    logic [QAW-1:0]               r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0]               r_rd_ptr, n_rd_ptr;
    logic [QCW-1:0]               r_fill, n_fill;
    logic                         cmd_known;
    logic                         push, pop;
    ppc_pkg::t_item_ctl           in_ctl;

    // Classify: unused command codes are consumed and dropped
    always_comb begin
        case (i_command)
            ppc_pkg::CMD_CLEAR, ppc_pkg::CMD_LOAD, ppc_pkg::CMD_QUERY: begin
                cmd_known = 1'b1;
            end
            default: begin
                cmd_known = 1'b0;
            end
        endcase
    end

    assign o_in_ready  = (r_fill != QCW'(ppc_pkg::QUEUE_DEPTH));
    assign o_q_valid   = (r_fill != '0);
    assign push        = i_in_valid && o_in_ready && cmd_known;
    assign pop         = o_q_valid && i_q_ready;
    assign in_ctl.cmd  = i_command;
    assign in_ctl.hole = i_ring_is_hole;
    assign in_ctl.ends = i_ring_ends;

    // Queue pointers and fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QAW'(ppc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QAW'(ppc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_fill = r_fill + 1'b1;
        end else if (pop && !push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // Queue storage, low coordinate bits only
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_ctl[r_wr_ptr] <= in_ctl;
            r_q_x[r_wr_ptr]   <= i_coord_x[COORD_BITS-1:0];
            r_q_y[r_wr_ptr]   <= i_coord_y[COORD_BITS-1:0];
        end
    end

    assign o_q_ctl = r_q_ctl[r_rd_ptr];
    assign o_q_x   = r_q_x[r_rd_ptr];
    assign o_q_y   = r_q_y[r_rd_ptr];

endmodule

// ----- rtl/core/ppc_back.sv -----
`timescale 1ns / 1ps

module ppc_back #(
    parameter int MAX_VERTICES = ppc_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = ppc_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    output logic                         o_q_ready,
    input  ppc_pkg::t_item_ctl           i_q_ctl,
    input  logic signed [COORD_BITS-1:0] i_q_x,
    input  logic signed [COORD_BITS-1:0] i_q_y,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_inside_res,
    output logic                         o_store_overflowed
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int WW = 2 * COORD_BITS + 2;

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_WALK  = 2'd1;
    localparam logic [1:0] B_DRAIN = 2'd2;
    localparam logic [1:0] B_DONE  = 2'd3;

    logic [1:0]                   r_state, n_state;
    logic [CW-1:0]                r_count, n_count;
    logic                         r_ovf, n_ovf;
    logic [CW-1:0]                r_rd_cnt, n_rd_cnt;
    logic                         r_dv, n_dv;
    logic                         r_wrap, n_wrap;
    logic                         r_at_first, n_at_first;
    logic                         r_parity, n_parity;
    logic                         r_in_outer, n_in_outer;
    logic                         r_in_hole, n_in_hole;
    logic                         r_out_valid, n_out_valid;
    logic                         r_out_inside, n_out_inside;
    logic                         r_out_ovf, n_out_ovf;
    logic                         r_hole_pend, n_hole_pend;
    logic signed [COORD_BITS-1:0] r_px, n_px, r_py, n_py;
    logic signed [COORD_BITS-1:0] r_first_x, n_first_x, r_first_y, n_first_y;
    logic signed [COORD_BITS-1:0] r_prev_x, n_prev_x, r_prev_y, n_prev_y;

    logic                         has_room;
    logic                         ram_we;
    logic [WW-1:0]                ram_wdata, ram_rdata;
    logic                         issue;
    logic                         walk_end;
    logic signed [COORD_BITS-1:0] cur_x, cur_y;
    logic                         cur_hole, cur_ends;
    logic                         agg_par;
    ppc_pkg::t_edge_tag           edge_tag;
    logic signed [COORD_BITS-1:0] edge_xi, edge_yi;
    ppc_pkg::t_edge_res           edge_res;

    // Store: one word per vertex, {ends, hole, y, x}
    assign has_room  = (r_count < CW'(MAX_VERTICES));
    assign o_q_ready = (r_state == B_IDLE);
    assign ram_we    = i_q_valid && o_q_ready && (i_q_ctl.cmd == ppc_pkg::CMD_LOAD) && has_room;
    assign ram_wdata = {i_q_ctl.ends, i_q_ctl.hole, i_q_y, i_q_x};

    ppc_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (issue),
        .i_raddr (r_rd_cnt[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign cur_x    = ram_rdata[COORD_BITS-1:0];
    assign cur_y    = ram_rdata[2*COORD_BITS-1:COORD_BITS];
    assign cur_hole = ram_rdata[2*COORD_BITS];
    assign cur_ends = ram_rdata[2*COORD_BITS+1];

    // Walk: hold back the next read after a closing vertex, leaving room for its wrap edge
    assign issue    = (r_state == B_WALK) && (r_rd_cnt < r_count) && !(r_dv && cur_ends);
    assign walk_end = (r_state == B_WALK) && (r_rd_cnt == r_count) && !r_dv && !r_wrap;

    // Edge request: vertex i is the current one, j the one before it
    always_comb begin
        edge_tag = '0;
        edge_xi  = cur_x;
        edge_yi  = cur_y;
        if (r_state == B_WALK) begin
            if (r_wrap) begin
                edge_tag.valid = 1'b1;
                edge_tag.last  = 1'b1;
                edge_tag.hole  = r_hole_pend;
                edge_xi        = r_first_x;
                edge_yi        = r_first_y;
            end else if (r_dv && !r_at_first) begin
                edge_tag.valid = 1'b1;
            end
        end
    end

    ppc_edge #(
        .COORD_BITS (COORD_BITS)
    ) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (edge_tag),
        .i_xi    (edge_xi),
        .i_yi    (edge_yi),
        .i_xj    (r_prev_x),
        .i_yj    (r_prev_y),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_res   (edge_res)
    );

    assign agg_par = r_parity ^ edge_res.toggle;

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_rd_cnt     = r_rd_cnt;
        n_dv         = issue;
        n_wrap       = r_wrap;
        n_at_first   = r_at_first;
        n_parity     = r_parity;
        n_in_outer   = r_in_outer;
        n_in_hole    = r_in_hole;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_inside = r_out_inside;
        n_out_ovf    = r_out_ovf;
        n_hole_pend  = r_hole_pend;
        n_px         = r_px;
        n_py         = r_py;
        n_first_x    = r_first_x;
        n_first_y    = r_first_y;
        n_prev_x     = r_prev_x;
        n_prev_y     = r_prev_y;

        case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_ctl.cmd)
                        ppc_pkg::CMD_CLEAR: begin
                            n_count = '0;
                            n_ovf   = 1'b0;
                        end
                        ppc_pkg::CMD_LOAD: begin
                            if (has_room) begin
                                n_count = r_count + CW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        ppc_pkg::CMD_QUERY: begin
                            n_state    = B_WALK;
                            n_rd_cnt   = '0;
                            n_wrap     = 1'b0;
                            n_at_first = 1'b1;
                            n_parity   = 1'b0;
                            n_in_outer = 1'b0;
                            n_in_hole  = 1'b0;
                            n_px       = i_q_x;
                            n_py       = i_q_y;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            B_WALK: begin
                if (issue) begin
                    n_rd_cnt = r_rd_cnt + CW'(1);
                end
                if (r_wrap) begin
                    n_wrap = 1'b0;
                end
                if (r_dv) begin
                    n_prev_x = cur_x;
                    n_prev_y = cur_y;
                    if (r_at_first) begin
                        n_first_x = cur_x;
                        n_first_y = cur_y;
                    end
                    if (cur_ends) begin
                        n_wrap      = 1'b1;
                        n_hole_pend = cur_hole;
                        n_at_first  = 1'b1;
                    end else begin
                        n_at_first = 1'b0;
                    end
                end
                if (walk_end) begin
                    n_state = B_DRAIN;
                end
            end
            B_DRAIN: begin
                if (!edge_res.busy) begin
                    n_state = B_DONE;
                end
            end
            B_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_inside = r_in_outer && !r_in_hole;
                    n_out_ovf    = r_ovf;
                    n_state      = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase

        // Crossing parity per ring; a ring's verdict lands with its wrap edge
        if (edge_res.valid) begin
            if (edge_res.last) begin
                n_parity = 1'b0;
                if (agg_par) begin
                    if (edge_res.hole) begin
                        n_in_hole = 1'b1;
                    end else begin
                        n_in_outer = 1'b1;
                    end
                end
            end else begin
                n_parity = agg_par;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_rd_cnt    <= '0;
            r_dv        <= 1'b0;
            r_wrap      <= 1'b0;
            r_at_first  <= 1'b1;
            r_parity    <= 1'b0;
            r_in_outer  <= 1'b0;
            r_in_hole   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_rd_cnt    <= n_rd_cnt;
            r_dv        <= n_dv;
            r_wrap      <= n_wrap;
            r_at_first  <= n_at_first;
            r_parity    <= n_parity;
            r_in_outer  <= n_in_outer;
            r_in_hole   <= n_in_hole;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_out_inside <= n_out_inside;
        r_out_ovf    <= n_out_ovf;
        r_hole_pend  <= n_hole_pend;
        r_px         <= n_px;
        r_py         <= n_py;
        r_first_x    <= n_first_x;
        r_first_y    <= n_first_y;
        r_prev_x     <= n_prev_x;
        r_prev_y     <= n_prev_y;
    end

    assign o_out_valid        = r_out_valid;
    assign o_inside_res       = r_out_inside;
    assign o_store_overflowed = r_out_ovf;

endmodule

// ----- dv/tb_polygon_point_containment.sv -----
`timescale 1ns / 1ps

module tb_polygon_point_containment;

    localparam int            MAXV          = ppc_pkg::MAX_VERTICES_DEF;
    localparam int            C_MIN         = -2147483647 - 1;
    localparam int            C_MAX         = 2147483647;
    localparam ppc_pkg::t_cmd CMD_UNUSED    = 2'd3;
    localparam int            RAND_PER_PHASE = 128;
    localparam int            BIG_RINGS     = 16;
    localparam int            DRAIN_CYCLES  = 2 * MAXV + 64;
    // worst case: every word a full-store query behind long stalls
    localparam longint LIMIT_NS    = 64'd60_000_000;

    typedef struct {
        logic held;
        logic ovf;
    } t_answer;

    // Tracks the vertex store and predicts the answer to each query word
    class ppc_answer_board;
        int      vx [MAXV];
        int      vy [MAXV];
        bit      v_hole [MAXV];
        bit      v_end [MAXV];
        int      stored;
        bit      dropped;
        t_answer answers_due [$];
        int      fail_count;
        int      words_taken;
        int      answers_checked;
        int      inside_seen;
        int      flagged_seen;

        // even-odd crossing test of one closed ring, wrap edge included
        function bit ring_holds(int first, int last, longint px, longint py);
            bit                 held;
            int                 j;
            longint             xi, yi, xj, yj, dy, dx;
            logic signed [67:0] a, b, lhs, rhs;
            held = 1'b0;
            for (int i = first; i <= last; i++) begin
                j  = (i == first) ? last : i - 1;
                xi = vx[i];
                yi = vy[i];
                xj = vx[j];
                yj = vy[j];
                if ((yi > py) != (yj > py)) begin
                    dy = yj - yi;
                    dx = xj - xi;
                    if (dy < 0) begin
                        dy = -dy;
                        dx = -dx;
                    end
                    // exact compare of (px-xi)*|dy| against dx'*(py-yi)
                    a   = px - xi;
                    b   = dy;
                    lhs = a * b;
                    a   = dx;
                    b   = py - yi;
                    rhs = a * b;
                    if (lhs < rhs)
                        held = !held;
                end
            end
            return held;
        endfunction

        function bit point_inside_shape(longint px, longint py);
            bit in_outer, in_hole;
            int start;
            in_outer = 1'b0;
            in_hole  = 1'b0;
            start    = 0;
            for (int k = 0; k < stored; k++) begin
                if (v_end[k]) begin
                    if (ring_holds(start, k, px, py)) begin
                        if (v_hole[k])
                            in_hole = 1'b1;
                        else
                            in_outer = 1'b1;
                    end
                    start = k + 1;
                end
            end
            return in_outer && !in_hole;
        endfunction

        // one accepted input word
        function void take_word(ppc_pkg::t_cmd cmd, int x, int y, bit hole, bit ends);
            t_answer ans;
            case (cmd)
                ppc_pkg::CMD_CLEAR: begin
                    stored  = 0;
                    dropped = 1'b0;
                    words_taken++;
                end
                ppc_pkg::CMD_LOAD: begin
                    if (stored < MAXV) begin
                        vx[stored]     = x;
                        vy[stored]     = y;
                        v_hole[stored] = hole;
                        v_end[stored]  = ends;
                        stored++;
                    end else begin
                        dropped = 1'b1;
                    end
                    words_taken++;
                end
                ppc_pkg::CMD_QUERY: begin
                    ans.held = point_inside_shape(x, y);
                    ans.ovf  = dropped;
                    answers_due.insert(answers_due.size(), ans);
                    words_taken++;
                end
                default: ;  // unused code, no effect
            endcase
        endfunction

        // one accepted result word
        function void check_answer(logic held, logic ovf);
            t_answer ans;
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual inside=%b ovf=%b",
                         $time, held, ovf);
                fail_count++;
                return;
            end
            ans = answers_due.pop_front();
            answers_checked++;
            if (ans.held) inside_seen++;
            if (ans.ovf)  flagged_seen++;
            if (held !== ans.held) begin
                $display("%0t: inside_res expected %b actual %b", $time, ans.held, held);
                fail_count++;
            end
            if (ovf !== ans.ovf) begin
                $display("%0t: store_overflowed expected %b actual %b", $time, ans.ovf, ovf);
                fail_count++;
            end
        endfunction

        function int due_count();
            return answers_due.size();
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [1:0]              i_command;
    logic signed [ppc_pkg::COORD_PORT_W-1:0] i_coord_x;
    logic signed [ppc_pkg::COORD_PORT_W-1:0] i_coord_y;
    logic                    i_ring_is_hole;
    logic                    i_ring_ends;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic                    o_inside_res;
    logic                    o_store_overflowed;

    ppc_answer_board board;
    int              in_idle_pct;
    int              out_idle_pct;
    int              sent_words;
    longint          box_cx, box_cy, box_span;
    int              recent_x [$];
    int              recent_y [$];

    polygon_point_containment dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_command          (i_command),
        .i_coord_x          (i_coord_x),
        .i_coord_y          (i_coord_y),
        .i_ring_is_hole     (i_ring_is_hole),
        .i_ring_ends        (i_ring_ends),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_inside_res       (o_inside_res),
        .o_store_overflowed (o_store_overflowed)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // watch both channels; receiver stalls at random
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                board.take_word(i_command, i_coord_x, i_coord_y, i_ring_is_hole, i_ring_ends);
            if (o_out_valid && i_out_ready)
                board.check_answer(o_inside_res, o_store_overflowed);
        end
        i_out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    // hold one word until accepted, with random gaps in front
    task automatic send_word(ppc_pkg::t_cmd cmd, int x, int y, bit hole, bit ends);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_coord_x      <= x;
        i_coord_y      <= y;
        i_ring_is_hole <= hole;
        i_ring_ends    <= ends;
        do @(posedge i_clk); while (!o_in_ready);
        if (cmd != CMD_UNUSED)
            sent_words++;
    endtask

    function automatic int box_coord(longint c, longint span);
        longint unsigned u, m;
        longint          v;
        u = {$urandom, $urandom};
        m = 2 * span + 1;
        v = c + longint'(u % m) - span;
        if (v < C_MIN) v = C_MIN;
        if (v > C_MAX) v = C_MAX;
        return int'(v);
    endfunction

    // region for the next shape: mostly tight, some wide, some full range
    task automatic pick_box();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: box_span = longint'($urandom_range(4, 64));
            5, 6, 7:       box_span = longint'($urandom_range(1 << 10, 1 << 20));
            8:             box_span = 64'd1 << 28;
            default:       box_span = 64'd1 << 31;
        endcase
        if (box_span >= (64'd1 << 31)) begin
            box_cx = 0;
            box_cy = 0;
        end else begin
            box_cx = box_coord(0, 64'd1 << 31);
            box_cy = box_coord(0, 64'd1 << 31);
        end
    endtask

    // hole flag only counts on the closing vertex; others get noise
    task automatic load_ring(int nv, bit hole_ring);
        int x, y;
        for (int v = 0; v < nv; v++) begin
            x = box_coord(box_cx, box_span);
            y = box_coord(box_cy, box_span);
            recent_x.insert(recent_x.size(), x);
            recent_y.insert(recent_y.size(), y);
            if (recent_x.size() > 64) begin
                void'(recent_x.pop_front());
                void'(recent_y.pop_front());
            end
            send_word(ppc_pkg::CMD_LOAD, x, y,
                      (v == nv - 1) ? hole_ring : 1'($urandom_range(0, 1)), v == nv - 1);
        end
    endtask

    // query inside the box, on a vertex, or level with a vertex
    task automatic query_near();
        int x, y, k;
        x = box_coord(box_cx, box_span);
        y = box_coord(box_cy, box_span);
        if (recent_x.size() != 0) begin
            k = $urandom_range(0, recent_x.size() - 1);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: ;
                4, 5, 6: begin
                    x = recent_x[k];
                    y = recent_y[k];
                end
                default: y = recent_y[k];
            endcase
        end
        send_word(ppc_pkg::CMD_QUERY, x, y, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    endtask

    // well-formed shapes with queries, plus some raw noise words
    task automatic random_phase(int n);
        int base, nrings, nv;
        base = sent_words;
        while (sent_words - base < n) begin
            if ($urandom_range(0, 99) < 80) begin
                if ($urandom_range(0, 99) < 85) begin
                    send_word(ppc_pkg::CMD_CLEAR, $urandom, $urandom,
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    recent_x.delete();
                    recent_y.delete();
                end
                pick_box();
                nrings = $urandom_range(1, 4);
                for (int r = 0; r < nrings; r++) begin
                    case ($urandom_range(0, 9))
                        0:       nv = $urandom_range(1, 2);
                        1:       nv = $urandom_range(9, 24);
                        default: nv = $urandom_range(3, 8);
                    endcase
                    load_ring(nv, (r > 0) && $urandom_range(0, 1));
                end
                // unclosed tail
                if ($urandom_range(0, 99) < 15)
                    for (int t = $urandom_range(1, 3); t > 0; t--)
                        send_word(ppc_pkg::CMD_LOAD, box_coord(box_cx, box_span),
                                  box_coord(box_cy, box_span), 1'($urandom_range(0, 1)),
                                  1'b0);
                for (int q = $urandom_range(2, 6); q > 0; q--)
                    query_near();
            end else begin
                send_word(ppc_pkg::t_cmd'($urandom_range(0, 3)), $urandom, $urandom,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // run limit
    initial begin
        #(LIMIT_NS);
        $display("polygon_point_containment: mismatch");
        $finish;
    end

    initial begin
        board          = new();
        sent_words     = 0;
        in_idle_pct    = 28;
        out_idle_pct   = 82;
        i_in_valid     <= 1'b0;
        i_command      <= ppc_pkg::CMD_CLEAR;
        i_coord_x      <= '0;
        i_coord_y      <= '0;
        i_ring_is_hole <= 1'b0;
        i_ring_ends    <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, unused code, square with triangular hole
        send_word(ppc_pkg::CMD_QUERY, 0, 0, 1'b0, 1'b0);
        send_word(CMD_UNUSED, C_MAX, C_MIN, 1'b1, 1'b1);
        send_word(ppc_pkg::CMD_LOAD, -100, -100, 1'b0, 1'b0);
        send_word(ppc_pkg::CMD_LOAD, 100, -100, 1'b1, 1'b0);
        send_word(ppc_pkg::CMD_LOAD, 100, 100, 1'b0, 1'b0);
        send_word(ppc_pkg::CMD_LOAD, -100, 100, 1'b0, 1'b1);
        send_word(ppc_pkg::CMD_QUERY, 0, 0, 1'b0, 1'b0);
        send_word(ppc_pkg::CMD_QUERY, 150, 0, 1'b0, 1'b0);
        send_word(ppc_pkg::CMD_LOAD, -50, -50, 1'b0, 1'b0);
        send_word(ppc_pkg::CMD_LOAD, 50, -50, 1'b0, 1'b0);
        send_word(ppc_pkg::CMD_LOAD, 0, 50, 1'b1, 1'b1);
        send_word(ppc_pkg::CMD_QUERY, 0, 0, 1'b0, 1'b0);
        send_word(ppc_pkg::CMD_QUERY, 80, 0, 1'b0, 1'b0);
        // two-vertex ring, one-vertex ring, then a huge unclosed tail
        send_word(ppc_pkg::CMD_LOAD, -200, -200, 1'b0, 1'b0);
        send_word(ppc_pkg::CMD_LOAD, 200, 200, 1'b0, 1'b1);
        send_word(ppc_pkg::CMD_LOAD, 90, 90, 1'b1, 1'b1);
        send_word(ppc_pkg::CMD_QUERY, 90, 90, 1'b0, 1'b0);
        send_word(ppc_pkg::CMD_LOAD, C_MIN, C_MIN, 1'b0, 1'b0);
        send_word(ppc_pkg::CMD_LOAD, C_MAX, C_MIN, 1'b0, 1'b0);
        send_word(ppc_pkg::CMD_LOAD, 0, C_MAX, 1'b0, 1'b0);
        send_word(ppc_pkg::CMD_QUERY, 500, 0, 1'b0, 1'b0);
        // full-range square
        send_word(ppc_pkg::CMD_CLEAR, C_MAX, C_MAX, 1'b1, 1'b1);
        send_word(ppc_pkg::CMD_LOAD, C_MIN, C_MIN, 1'b0, 1'b0);
        send_word(ppc_pkg::CMD_LOAD, C_MAX, C_MIN, 1'b0, 1'b0);
        send_word(ppc_pkg::CMD_LOAD, C_MAX, C_MAX, 1'b0, 1'b0);
        send_word(ppc_pkg::CMD_LOAD, C_MIN, C_MAX, 1'b0, 1'b1);
        send_word(ppc_pkg::CMD_QUERY, 0, 0, 1'b0, 1'b0);
        send_word(ppc_pkg::CMD_QUERY, C_MIN, C_MIN, 1'b1, 1'b1);
        send_word(ppc_pkg::CMD_QUERY, C_MAX, C_MAX, 1'b0, 1'b0);
        send_word(ppc_pkg::CMD_CLEAR, 0, 0, 1'b0, 1'b0);
        send_word(ppc_pkg::CMD_QUERY, 0, 0, 1'b0, 1'b0);
        random_phase(RAND_PER_PHASE);

        // larger multi-ring store with long walks, a few extra rings, then clear
        in_idle_pct  = 82;
        out_idle_pct = 28;
        send_word(ppc_pkg::CMD_CLEAR, 0, 0, 1'b0, 1'b0);
        for (int r = 0; r < BIG_RINGS; r++) begin
            box_cx   = box_coord(0, 64'd1 << 20);
            box_cy   = box_coord(0, 64'd1 << 20);
            box_span = 64'd1 << 21;
            load_ring(8, r % 5 == 4);
        end
        query_near();
        send_word(ppc_pkg::CMD_LOAD, 1, 2, 1'b0, 1'b1);
        send_word(ppc_pkg::CMD_LOAD, C_MAX, C_MIN, 1'b1, 1'b1);
        send_word(ppc_pkg::CMD_LOAD, 3, 4, 1'b0, 1'b0);
        query_near();
        query_near();
        send_word(ppc_pkg::CMD_CLEAR, 0, 0, 1'b0, 1'b0);
        send_word(ppc_pkg::CMD_QUERY, 0, 0, 1'b0, 1'b0);
        recent_x.delete();
        recent_y.delete();
        random_phase(RAND_PER_PHASE);

        in_idle_pct  = 0;
        out_idle_pct = 0;
        random_phase(RAND_PER_PHASE);
        i_in_valid <= 1'b0;

        // drain
        while (board.due_count() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words; compared %0d query answers (%0d inside, %0d after overflow).",
                 board.words_taken, board.answers_checked, board.inside_seen,
                 board.flagged_seen);
        if (board.fail_count == 0 && board.due_count() == 0)
            $display("polygon_point_containment: match");
        else
            $display("polygon_point_containment: mismatch");
        $finish;
    end

endmodule
